@@ hdl/fbpa_pkg.sv @@
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);
   // A link holds a block index or NUM_BLOCKS, which marks the end of the list.
   localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LINK_W-1:0] link_type;

   // One word of the block store: the in-use flag and the next link.
   typedef struct packed {
      logic     in_use;
      link_type link;
   } entry_type;

   // Write request from the control logic to the block store.
   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type entry;
   } store_wr_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_FALLBACK = 2'd1,
      STATUS_EXTERNAL = 2'd2,
      STATUS_ERROR    = 2'd3
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

endpackage

@@ hdl/fbpa_entry_store.sv @@
`timescale 1ns / 1ps

module fbpa_entry_store
   import fbpa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rd_en,
   input  addr_type     rd_addr,
   output entry_type    rd_entry,
   input  store_wr_type wr
);

   entry_type              mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]  valid_ff;
   logic [NUM_BLOCKS-1:0]  valid_in;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;
   addr_type               rd_addr_ff;

   // An entry never written since reset reads as free, linked to the next block.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry.in_use = 1'b0;
         rd_entry.link   = LINK_W'(rd_addr_ff) + LINK_W'(1);
      end
   end

endmodule

@@ hdl/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

// Fixed-size block pool allocator. The pool of NUM_BLOCKS blocks is kept as a
// LIFO free list: a head register plus one store word per block that holds the
// block's in-use flag and its next link. After reset the list runs block 0,
// 1, 2 and so on, and block_size is 64. An allocate beat pops the head block,
// or reports fallback when the list is empty or the request is larger than
// block_size. A free beat of a pool block that is in use pushes it back on the
// head; a free of an external block is passed through, and a free of a block
// that is not in use is reported as an error and changes nothing. Every
// request beat yields exactly one response beat. Each request has a read step,
// which reads the block's store word from the synchronous memory, and an
// execute step, which updates it and loads the response register. A new
// request is taken while the previous response still waits to be accepted,
// but the execute step holds until the response register is free. No
// clearing pass is needed after reset. block_size is written through the csr
// port, which is always ready; write it only while no request is in flight.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_request_size,
   input  logic [5:0]  req_block_index,
   input  logic        req_from_pool,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_granted_index,
   output logic        rsp_granted_from_pool
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  block_size_ff, block_size_in;
   link_type     free_head_ff, free_head_in;

   // Request captured at acceptance.
   logic         op_ff;
   logic [15:0]  size_ff;
   logic [5:0]   idx_ff;
   logic         pool_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff, status_in;
   logic [5:0]   granted_ff, granted_in;
   logic         granted_pool_ff, granted_pool_in;

   logic         req_accept;
   logic         exec_fire;
   addr_type     rd_addr;
   entry_type    rd_entry;
   store_wr_type wr;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The store is read with the head for an allocate and with the freed
   // index for a free; the data is ready in the execute cycle.
   assign rd_addr = (req_opcode == OP_FREE) ? ADDR_W'(req_block_index)
                                            : free_head_ff[ADDR_W-1:0];

   fbpa_entry_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // The execute step may only load the response register when it is empty
   // or its beat is leaving in this cycle.
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      block_size_in   = block_size_ff;
      free_head_in    = free_head_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      status_in       = status_ff;
      granted_in      = granted_ff;
      granted_pool_in = granted_pool_ff;
      wr              = '0;

      if (csr_valid && csr_ready) begin
         block_size_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               granted_in      = '0;
               granted_pool_in = 1'b0;
               if (op_ff == OP_ALLOC) begin
                  if ((free_head_ff == LINK_W'(NUM_BLOCKS)) || (size_ff > block_size_ff)) begin
                     status_in = STATUS_FALLBACK;
                  end else begin
                     // Pop: the head block goes in use and its link becomes the head.
                     wr.en           = 1'b1;
                     wr.addr         = free_head_ff[ADDR_W-1:0];
                     wr.entry.in_use = 1'b1;
                     wr.entry.link   = rd_entry.link;
                     free_head_in    = rd_entry.link;
                     status_in       = STATUS_DONE;
                     granted_in      = 6'(free_head_ff);
                     granted_pool_in = 1'b1;
                  end
               end else if (!pool_ff) begin
                  status_in = STATUS_EXTERNAL;
               end else if ((LINK_W'(idx_ff) >= LINK_W'(NUM_BLOCKS)) || !rd_entry.in_use) begin
                  status_in = STATUS_ERROR;
               end else begin
                  // Push: the freed block links to the old head and becomes the head.
                  wr.en           = 1'b1;
                  wr.addr         = ADDR_W'(idx_ff);
                  wr.entry.in_use = 1'b0;
                  wr.entry.link   = free_head_ff;
                  free_head_in    = LINK_W'(idx_ff);
                  status_in       = STATUS_DONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         block_size_ff <= 16'd64;
         free_head_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         block_size_ff <= block_size_in;
         free_head_ff  <= free_head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_opcode;
         size_ff <= req_request_size;
         idx_ff  <= req_block_index;
         pool_ff <= req_from_pool;
      end
      status_ff       <= status_in;
      granted_ff      <= granted_in;
      granted_pool_ff <= granted_pool_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_granted_index     = granted_ff;
   assign rsp_granted_from_pool = granted_pool_ff;

`ifndef SYNTHESIS
   // An accepted request always moves into the execute step.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

   // A new response appears only right after an execute step.
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised without an execute step");

   // The head is a block index or the end-of-list mark.
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= LINK_W'(NUM_BLOCKS))
      else $error("free list head out of range");

   // A grant from the pool is always reported as done.
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && granted_pool_ff) |-> (status_ff == STATUS_DONE))
      else $error("pool grant with wrong status");
`endif

endmodule

@@ tb/tb_fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
   import fbpa_pkg::*;

   // Expected contents of one response beat.
   typedef struct packed {
      status_type status;
      addr_type   index;
      logic       from_pool;
   } alloc_response_type;

   // One row of the directed stimulus table. When has_typed is set, the row
   // carries its own expected response; otherwise the pool model supplies it.
   typedef struct packed {
      logic               opcode;
      logic [15:0]        size;
      addr_type           index;
      logic               from_pool;
      logic               has_typed;
      alloc_response_type typed;
   } directed_row_type;

   localparam int DIRECTED_ROWS  = 19;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 206;
   localparam int MAX_GAP        = 12;
   localparam int IDLE_LIMIT     = 500;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [15:0] req_request_size;
   logic [5:0]  req_block_index;
   logic        req_from_pool;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_granted_index;
   logic        rsp_granted_from_pool;

   // Shadow copy of the allocator: block size, free list head, next links and
   // in-use flags; the list state is advanced when a request beat is accepted.
   logic [15:0] model_block_size;
   link_type    model_head;
   link_type    model_link [NUM_BLOCKS];
   logic        model_busy [NUM_BLOCKS];

   // Responses still owed by the allocator, oldest first.
   alloc_response_type owed_responses[$];

   int  error_count;
   int  idle_cycles;
   int  rsp_hold_left;
   bit  req_no_gaps;
   bit  rsp_no_stalls;

   // Directed table, starting from the reset state (block_size 64, list
   // 0, 1, 2, ...). The typed rows cover the reset head, the size limit at
   // both sides, external frees, frees of blocks not in use, a double free and
   // the LIFO reuse of a freed block. The later rows mix pops and pushes and
   // are left to the model.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_ALLOC, 16'd0,     6'd0,  1'b0, 1'b1, '{STATUS_DONE,     6'd0, 1'b1}},
      '{OP_ALLOC, 16'd64,    6'd63, 1'b1, 1'b1, '{STATUS_DONE,     6'd1, 1'b1}},
      '{OP_ALLOC, 16'd65,    6'd0,  1'b0, 1'b1, '{STATUS_FALLBACK, 6'd0, 1'b0}},
      '{OP_ALLOC, 16'hFFFF,  6'd42, 1'b1, 1'b1, '{STATUS_FALLBACK, 6'd0, 1'b0}},
      '{OP_FREE,  16'hFFFF,  6'd63, 1'b0, 1'b1, '{STATUS_EXTERNAL, 6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd0,  1'b0, 1'b1, '{STATUS_EXTERNAL, 6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd63, 1'b1, 1'b1, '{STATUS_ERROR,    6'd0, 1'b0}},
      '{OP_FREE,  16'h5555,  6'd2,  1'b1, 1'b1, '{STATUS_ERROR,    6'd0, 1'b0}},
      '{OP_FREE,  16'hAAAA,  6'd0,  1'b1, 1'b1, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd0,  1'b1, 1'b1, '{STATUS_ERROR,    6'd0, 1'b0}},
      '{OP_ALLOC, 16'd1,     6'd21, 1'b1, 1'b1, '{STATUS_DONE,     6'd0, 1'b1}},
      '{OP_ALLOC, 16'd63,    6'd0,  1'b0, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd1,  1'b1, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd2,  1'b1, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_ALLOC, 16'd32,    6'd0,  1'b0, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_ALLOC, 16'd32,    6'd0,  1'b0, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_ALLOC, 16'd32,    6'd0,  1'b0, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd21, 1'b1, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}},
      '{OP_FREE,  16'd0,     6'd42, 1'b1, 1'b0, '{STATUS_DONE,     6'd0, 1'b0}}
   };

   // Block size and share of allocate beats for each random phase. The extremes
   // of block_size are both visited; the allocate-heavy phase with the largest
   // block size drains the list so that empty-list fallbacks are exercised.
   logic [15:0] phase_block_size [PHASES] = '{16'd1, 16'hFFFF, 16'd64, 16'd9, 16'd0};
   int          phase_alloc_pct  [PHASES] = '{60, 80, 30, 50, 55};

   fixed_block_pool_allocator uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_request_size      (req_request_size),
      .req_block_index       (req_block_index),
      .req_from_pool         (req_from_pool),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_granted_index     (rsp_granted_index),
      .rsp_granted_from_pool (rsp_granted_from_pool)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Advances the shadow pool by one request and returns the response that
   // the allocator must give for it.
   function automatic alloc_response_type pool_response(input logic opcode,
         input logic [15:0] size, input addr_type index, input logic from_pool);
      alloc_response_type r;
      addr_type           blk;
      r.status    = STATUS_DONE;
      r.index     = '0;
      r.from_pool = 1'b0;
      if (opcode == OP_ALLOC) begin
         if (model_head >= NUM_BLOCKS || size > model_block_size) begin
            r.status = STATUS_FALLBACK;
         end else begin
            blk              = model_head[ADDR_W-1:0];
            model_head       = model_link[blk];
            model_busy[blk]  = 1'b1;
            r.index          = blk;
            r.from_pool      = 1'b1;
         end
      end else if (from_pool == 1'b0) begin
         r.status = STATUS_EXTERNAL;
      end else if (model_busy[index] == 1'b0) begin
         // Freeing a block that is not handed out leaves the list untouched.
         r.status = STATUS_ERROR;
      end else begin
         model_busy[index] = 1'b0;
         model_link[index] = model_head;
         model_head        = link_type'(index);
      end
      return r;
   endfunction

   // Drives one request beat and waits for it to be accepted. It is entered
   // and left at a falling edge. The gap before the beat is drawn here; when
   // it is zero, valid simply stays high and only the payload changes.
   task automatic send_request(input logic opcode, input logic [15:0] size,
         input addr_type index, input logic from_pool, input logic has_typed,
         input alloc_response_type typed);
      int                 gap;
      alloc_response_type predicted;
      if ($urandom_range(0, 39) == 0) begin
         req_no_gaps = ~req_no_gaps;
      end
      gap = req_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= opcode;
      req_request_size <= size;
      req_block_index  <= index;
      req_from_pool    <= from_pool;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = pool_response(opcode, size, index, from_pool);
      owed_responses.push_back(has_typed ? typed : predicted);
      @(negedge clock);
   endtask

   // Builds one random request. Most frees hand back a block that is really
   // in use, so the list keeps moving; the rest are external frees and frees
   // of arbitrary blocks. Sizes cluster around block_size but cover the full
   // 16-bit range.
   task automatic send_random_request(input int alloc_pct);
      logic        opcode;
      logic [16:0] size;
      addr_type    index;
      logic        from_pool;
      int          busy_blocks[$];
      int          pick;
      opcode    = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      index     = addr_type'($urandom_range(0, NUM_BLOCKS - 1));
      from_pool = ($urandom_range(0, 9) != 0);
      pick      = $urandom_range(0, 9);
      if (pick < 6) begin
         size = 17'($urandom_range(0, model_block_size));
      end else if (pick < 8) begin
         size = 17'($urandom_range(0, 16'hFFFF));
      end else if (pick == 8 || model_block_size == 16'hFFFF) begin
         size = {1'b0, model_block_size};
      end else begin
         size = {1'b0, model_block_size} + 17'd1;
      end
      if (opcode == OP_FREE && from_pool && $urandom_range(0, 99) < 85) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (model_busy[i]) begin
               busy_blocks.push_back(i);
            end
         end
         if (busy_blocks.size() > 0) begin
            index = addr_type'(busy_blocks[$urandom_range(0, busy_blocks.size() - 1)]);
         end
      end
      send_request(opcode, size[15:0], index, from_pool, 1'b0, '0);
   endtask

   // Lowers valid and waits until every owed response has been taken, so that
   // the allocator is idle before the register changes.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (owed_responses.size() > 0) @(negedge clock);
   endtask

   // Writes block_size through the csr port. Entered and left at a falling edge.
   task automatic write_block_size(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_block_size = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: each accepted beat is compared with the oldest owed
   // response, and a fresh stall length is drawn for the next one.
   always @(posedge clock) begin
      alloc_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            $display("%0t: response beat with nothing owed: status %0d index %0d pool %0d",
                     $time, rsp_status, rsp_granted_index, rsp_granted_from_pool);
            error_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_granted_index !== want.index) begin
               $display("%0t: granted_index expected %0d actual %0d", $time, want.index,
                        rsp_granted_index);
               error_count++;
            end
            if (rsp_granted_from_pool !== want.from_pool) begin
               $display("%0t: granted_from_pool expected %0d actual %0d", $time,
                        want.from_pool, rsp_granted_from_pool);
               error_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            rsp_no_stalls = ~rsp_no_stalls;
         end
         rsp_hold_left = rsp_no_stalls ? 0 : $urandom_range(0, MAX_GAP);
      end
   end

   // The stall drawn for a response is applied from the next falling edge on.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: too many cycles in a row without a beat on any channel means
   // the allocator has hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] size_setting;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_opcode       = OP_ALLOC;
      req_request_size = '0;
      req_block_index  = '0;
      req_from_pool    = 1'b0;
      rsp_stall        = 1'b0;
      error_count      = 0;
      idle_cycles      = 0;
      rsp_hold_left    = 0;
      req_no_gaps      = 1'b0;
      rsp_no_stalls    = 1'b0;

      // The shadow pool starts where the allocator starts after reset.
      model_block_size = 16'd64;
      model_head       = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         model_link[i] = link_type'(i + 1);
         model_busy[i] = 1'b0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request(directed_rows[row].opcode, directed_rows[row].size,
                      directed_rows[row].index, directed_rows[row].from_pool,
                      directed_rows[row].has_typed, directed_rows[row].typed);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_idle();
         size_setting = phase_block_size[phase];
         if (size_setting == 16'd0) begin
            size_setting = 16'($urandom_range(1, 16'hFFFF));
         end
         write_block_size(size_setting);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_request(phase_alloc_pct[phase]);
         end
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && owed_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
